// File: rtl/core/lrg_pkg.sv
package lrg_pkg;

  // Lehmer generator constants: modulus 2^31 - 1, multiplier 48271.
  localparam logic [30:0] LRG_MOD  = 31'h7FFF_FFFF;
  localparam logic [16:0] LRG_MULT = 17'd48271;
  localparam logic [30:0] LRG_INIT = 31'd123456789;

  // Operation codes carried on in_tuser.
  localparam logic [1:0] OP_SEED  = 2'd0;
  localparam logic [1:0] OP_DRAW  = 2'd1;
  localparam logic [1:0] OP_BERN  = 2'd2;
  localparam logic [1:0] OP_RANGE = 2'd3;

  // Operand pair presented to the shared multiplier.
  typedef struct packed {
    logic [30:0] a;
    logic [16:0] b;
  } lrg_mul_req_t;

endpackage

// File: rtl/core/lrg_mul.sv
module lrg_mul
  import lrg_pkg::*;
(
  input  logic         clk,
  input  lrg_mul_req_t req,
  output logic [47:0]  prod_r
);

  // Registered 31 x 17 unsigned multiplier; the product appears in the cycle
  // after the operands.
  always_ff @(posedge clk) begin
    prod_r <= {17'd0, req.a} * {31'd0, req.b};
  end

endmodule

// File: rtl/core/lehmer_random_generator.sv
// Lehmer generator with multiplier 48271 and modulus 2^31 - 1.
// A reseed passes the seed step; a range with low bound above high bound goes
// straight to the output load; draw and Bernoulli pass multiply and reduce; a
// range then passes the slice multiplies, accumulate and divide steps. A new word
// is taken only once the last result is loaded. Reset (rst_n low, synchronous)
// loads the state with 123456789 and empties the output register.
module lehmer_random_generator
  import lrg_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // in_tdata, lowest bit up: seed_value[31:0], threshold[30:0],
  // low_bound[31:0], high_bound[31:0], one pad bit.
  input  logic [127:0] in_tdata,
  // in_tuser: op[1:0].
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_tdata, lowest bit up: state_out[30:0], coin, range_value[31:0].
  output logic [63:0]  out_tdata,
  // out_tuser: error.
  output logic         out_tuser
);

  // Sequencer states. A range draw walks through all but the seed step; the other
  // operations and an inverted range take a short cut to the output load step.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SEED = 4'd1;
  localparam logic [3:0] S_MULA = 4'd2;
  localparam logic [3:0] S_REDA = 4'd3;
  localparam logic [3:0] S_MULL = 4'd4;
  localparam logic [3:0] S_MULH = 4'd5;
  localparam logic [3:0] S_ACC  = 4'd6;
  localparam logic [3:0] S_DIVA = 4'd7;
  localparam logic [3:0] S_DIVB = 4'd8;
  localparam logic [3:0] S_DIVC = 4'd9;
  localparam logic [3:0] S_DONE = 4'd10;

  logic [3:0]   st_r, st_nxt;
  logic [30:0]  lstate_r, lstate_nxt;
  logic [1:0]   op_r;
  logic [31:0]  seed_r;
  logic [30:0]  thr_r;
  logic [31:0]  low_r;
  logic [32:0]  span_r;
  logic         err_r;
  logic [63:0]  acc_r;
  logic [32:0]  quo_r;
  logic [33:0]  rem_r;
  logic [31:0]  res_r;
  logic         out_valid_r;
  logic [63:0]  out_data_r;
  logic         out_err_r;

  lrg_mul_req_t mul_req;
  logic [47:0]  prod;

  logic         accept;
  logic         out_free;
  logic [32:0]  lo_ext, hi_ext, span_calc;
  logic         range_bad;
  logic [31:0]  seed_mag;
  logic [31:0]  mod_sum;
  logic [31:0]  mod_red;
  logic [30:0]  adv_state;
  logic [32:0]  quo_fix;
  logic         coin;

  assign accept   = in_tvalid && in_tready;
  assign in_tready = (st_r == S_IDLE);
  assign out_free = !out_valid_r || out_tready;

  // Range width, one more than high minus low, needs 33 bits.
  assign lo_ext    = {in_tdata[94], in_tdata[94:63]};
  assign hi_ext    = {in_tdata[126], in_tdata[126:95]};
  assign span_calc = hi_ext - lo_ext + 33'd1;
  assign range_bad = $signed(in_tdata[94:63]) > $signed(in_tdata[126:95]);

  // Magnitude of the seed; the most negative value gives 2^31 as unsigned.
  assign seed_mag = seed_r[31] ? (32'd0 - seed_r) : seed_r;

  // Mersenne reduction of state * 48271: the high and low halves add to a
  // value below twice the modulus, so one subtraction finishes it. A zero
  // remainder becomes the modulus itself.
  assign mod_sum   = {15'd0, prod[47:31]} + {1'b0, prod[30:0]};
  assign mod_red   = (mod_sum > {1'b0, LRG_MOD}) ? (mod_sum - {1'b0, LRG_MOD}) : mod_sum;
  assign adv_state = (mod_red == 32'd0) ? LRG_MOD : mod_red[30:0];

  // Last correction step of the division by the modulus.
  assign quo_fix = (rem_r >= {3'd0, LRG_MOD}) ? (quo_r + 33'd1) : quo_r;

  assign coin = (op_r == OP_BERN) && (lstate_r < thr_r);

  // The multiplier takes the state against either the Lehmer multiplier or
  // one 17-bit slice of the range width.
  always_comb begin
    mul_req.a = lstate_r;
    case (st_r)
      S_MULL:  mul_req.b = span_r[16:0];
      S_MULH:  mul_req.b = {1'b0, span_r[32:17]};
      default: mul_req.b = LRG_MULT;
    endcase
  end

  lrg_mul u_mul (
    .clk    (clk),
    .req    (mul_req),
    .prod_r (prod)
  );

  always_comb begin
    st_nxt     = st_r;
    lstate_nxt = lstate_r;
    case (st_r)
      S_IDLE: begin
        if (accept) begin
          if (in_tuser == OP_SEED) begin
            st_nxt = S_SEED;
          end else if ((in_tuser == OP_RANGE) && range_bad) begin
            st_nxt = S_DONE;
          end else begin
            st_nxt = S_MULA;
          end
        end
      end
      S_SEED: begin
        lstate_nxt = (seed_mag >= {1'b0, LRG_MOD}) ? 31'(seed_mag - {1'b0, LRG_MOD})
                                                   : seed_mag[30:0];
        st_nxt = S_DONE;
      end
      S_MULA: st_nxt = S_REDA;
      S_REDA: begin
        lstate_nxt = adv_state;
        st_nxt = (op_r == OP_RANGE) ? S_MULL : S_DONE;
      end
      S_MULL: st_nxt = S_MULH;
      S_MULH: st_nxt = S_ACC;
      S_ACC:  st_nxt = S_DIVA;
      S_DIVA: st_nxt = S_DIVB;
      S_DIVB: st_nxt = S_DIVC;
      S_DIVC: st_nxt = S_DONE;
      S_DONE: begin
        if (out_free) begin
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // Control state and the generator state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      lstate_r    <= LRG_INIT;
      out_valid_r <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      lstate_r <= lstate_nxt;
      if ((st_r == S_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Operand capture, the datapath of the range draw and the output register load.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_tuser;
      seed_r <= in_tdata[31:0];
      thr_r  <= in_tdata[62:32];
      low_r  <= in_tdata[94:63];
      span_r <= span_calc;
      err_r  <= (in_tuser == OP_RANGE) && range_bad;
    end
    case (st_r)
      // Product of the low slice of the range width.
      S_MULH: acc_r <= {16'd0, prod};
      // Add the high slice, weighted by 2^17; the total fits in 64 bits.
      S_ACC:  acc_r <= acc_r + {prod[46:0], 17'd0};
      // Division by 2^31 - 1: take the product as q * 2^31 + r, then fold
      // the quotient back into the remainder twice.
      S_DIVA: begin
        quo_r <= acc_r[63:31];
        rem_r <= {3'd0, acc_r[30:0]} + {1'b0, acc_r[63:31]};
      end
      S_DIVB: begin
        quo_r <= quo_r + {30'd0, rem_r[33:31]};
        rem_r <= {3'd0, rem_r[30:0]} + {31'd0, rem_r[33:31]};
      end
      S_DIVC: res_r <= low_r + quo_fix[31:0];
      default: ;
    endcase
    if ((st_r == S_DONE) && out_free) begin
      out_data_r <= {((op_r == OP_RANGE) && !err_r) ? res_r : 32'd0, coin, lstate_r};
      out_err_r  <= err_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_err_r;

endmodule

// File: rtl/core/lrg_checker.sv
module lrg_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [63:0]  out_tdata,
  input logic         out_tuser
);

  // A stalled result word holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // The block works on one word at a time: it is busy right after an accept.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while an operation is in progress");

  // An error word carries neither a coin nor a range value.
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> !out_tdata[31] && (out_tdata[63:32] == 32'd0))
    else $error("error word carries result data");

  // Reset empties the output register.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind lehmer_random_generator lrg_checker u_lrg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// File: bench/lehmer_random_generator_tb.sv
// Testbench for the Lehmer generator with multiplier 48271 and modulus 2^31 - 1.
//
// Every input word carries an operation on in_tuser: reseed, raw draw, Bernoulli test
// or a uniform integer in a range. The bench keeps its own copy of the generator state.
// For each word that the block accepts, it works out the result word that must come
// back. A monitor compares each result word, field by field, with the oldest pending
// expectation. Both sides idle at random. One long receiver hold-off lets the block
// fill up and push back on its input.
module lehmer_random_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lrg_pkg::*;

  // One result word as it leaves the block, unpacked into its fields.
  typedef struct packed {
    logic [30:0] state;
    logic        coin;
    logic [31:0] range_value;
    logic        error;
  } lehmer_result_t;

  // One row of the directed stimulus. Where typed is set, known_res holds a result that
  // can be read straight off the definition. Otherwise the predictor supplies it.
  typedef struct packed {
    logic [1:0]     op;
    logic [31:0]    seed;
    logic [30:0]    thr;
    logic [31:0]    lo;
    logic [31:0]    hi;
    logic           typed;
    lehmer_result_t known_res;
  } directed_row_t;

  localparam logic [31:0] INT_MIN = 32'h8000_0000;
  localparam logic [31:0] INT_MAX = 32'h7FFF_FFFF;
  localparam logic [30:0] THR_MAX = 31'h7FFF_FFFF;

  localparam int DIRECTED_COUNT = 22;
  localparam int RANDOM_WORDS   = 1928;
  localparam int HOLD_AFTER     = 300;   // accepted words before the long receiver stall
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 20;    // margin after the slowest operation completes

  // The trace starts from the reset state and walks through the corner cases: an inverted
  // range before any advance, the most negative seed (magnitude 2^31 folds to 1), and zero
  // seeds by 0 and by +-M. Zero advances to M and then stays at M. From M, a range draw
  // lands on high + 1, which wraps at the top of the 32-bit range. A seed just below
  // M follows. Last come bounds and thresholds given on operations that must ignore them.
  localparam directed_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    '{OP_RANGE, 32'd0,       31'd0,   32'd5,   -32'sd5, 1'b1,
      '{31'd123456789, 1'b0, 32'd0, 1'b1}},
    '{OP_SEED,  INT_MIN,     31'd0,   32'd0,   32'd0,   1'b1, '{31'd1, 1'b0, 32'd0, 1'b0}},
    '{OP_DRAW,  32'd0,       31'd0,   32'd0,   32'd0,   1'b1, '{31'd48271, 1'b0, 32'd0, 1'b0}},
    '{OP_BERN,  32'd0,       31'd0,   32'd0,   32'd0,   1'b0, '0},
    '{OP_SEED,  32'd0,       31'd0,   32'd0,   32'd0,   1'b1, '{31'd0, 1'b0, 32'd0, 1'b0}},
    '{OP_DRAW,  32'd0,       31'd0,   32'd0,   32'd0,   1'b1, '{LRG_MOD, 1'b0, 32'd0, 1'b0}},
    '{OP_BERN,  32'd0,       THR_MAX, 32'd0,   32'd0,   1'b1, '{LRG_MOD, 1'b0, 32'd0, 1'b0}},
    '{OP_RANGE, 32'd0,       31'd0,   32'd0,   32'd9,   1'b1, '{LRG_MOD, 1'b0, 32'd10, 1'b0}},
    '{OP_RANGE, 32'd0,       31'd0,   INT_MAX, INT_MAX, 1'b1, '{LRG_MOD, 1'b0, INT_MIN, 1'b0}},
    '{OP_RANGE, 32'd0,       31'd0,   INT_MIN, INT_MAX, 1'b1, '{LRG_MOD, 1'b0, INT_MIN, 1'b0}},
    '{OP_SEED,  INT_MAX,     31'd0,   32'd0,   32'd0,   1'b1, '{31'd0, 1'b0, 32'd0, 1'b0}},
    '{OP_SEED,  -32'sd2147483647, 31'd0, 32'd0, 32'd0,  1'b1, '{31'd0, 1'b0, 32'd0, 1'b0}},
    '{OP_SEED,  32'd2147483646, 31'd0, 32'd0,  32'd0,   1'b1,
      '{31'd2147483646, 1'b0, 32'd0, 1'b0}},
    '{OP_DRAW,  32'd0,       31'd0,   32'd0,   32'd0,   1'b0, '0},
    '{OP_BERN,  32'd0,       THR_MAX, 32'd0,   32'd0,   1'b0, '0},
    '{OP_RANGE, 32'd0,       31'd0,   INT_MIN, INT_MIN, 1'b0, '0},
    '{OP_RANGE, 32'd0,       31'd0,   INT_MAX, INT_MIN, 1'b0, '0},
    '{OP_RANGE, 32'd0,       31'd0,   INT_MIN, INT_MAX, 1'b0, '0},
    '{OP_SEED,  32'hFFFF_FFFF, THR_MAX, INT_MAX, INT_MIN, 1'b1, '{31'd1, 1'b0, 32'd0, 1'b0}},
    '{OP_DRAW,  32'hFFFF_FFFF, THR_MAX, INT_MAX, INT_MIN, 1'b1,
      '{31'd48271, 1'b0, 32'd0, 1'b0}},
    '{OP_BERN,  INT_MIN,     31'd0,   INT_MAX, INT_MIN, 1'b0, '0},
    '{OP_RANGE, INT_MAX,     THR_MAX, 32'd0,   32'd0,   1'b0, '0}
  };

  logic         clk = 1'b0;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;   // seed_value, threshold, low_bound, high_bound, pad bit
  logic [1:0]   in_tuser;   // op
  logic         out_tvalid;
  logic         out_tready;
  logic [63:0]  out_tdata;  // state_out, coin, range_value
  logic         out_tuser;  // error

  // The bench's own copy of the generator state and the results still owed by the block.
  logic [30:0]    gen_state;
  lehmer_result_t pending_results[$];

  int  failures = 0;
  int  words_accepted = 0;
  int  op_count[4] = '{0, 0, 0, 0};
  int  range_errors = 0;
  bit  quiet_phase = 1'b0;   // when set, neither side idles
  bit  hold_done = 1'b0;

  lehmer_random_generator DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // One Lehmer step. A product that is a multiple of M gives M rather than zero.
  function automatic logic [30:0] lehmer_next(input logic [30:0] s);
    logic [63:0] rem;
    rem = (64'(s) * 64'(LRG_MULT)) % 64'(LRG_MOD);
    return (rem == 64'd0) ? LRG_MOD : rem[30:0];
  endfunction

  // Applies one accepted word to gen_state and returns the result word it must produce.
  function automatic lehmer_result_t lehmer_apply(input logic [1:0] op,
                                                  input logic [31:0] seed,
                                                  input logic [30:0] thr,
                                                  input logic [31:0] lo,
                                                  input logic [31:0] hi);
    lehmer_result_t res;
    logic [31:0]    mag;
    logic [63:0]    span;
    logic [63:0]    scaled;
    res = '0;
    case (op)
      OP_SEED: begin
        // Two's complement negation of -2^31 gives 2^31 as an unsigned magnitude.
        mag = seed[31] ? (~seed + 32'd1) : seed;
        gen_state = 31'(64'(mag) % 64'(LRG_MOD));
      end
      OP_DRAW: gen_state = lehmer_next(gen_state);
      OP_BERN: begin
        gen_state = lehmer_next(gen_state);
        res.coin = (gen_state < thr);
      end
      default: begin
        if ($signed(lo) > $signed(hi)) begin
          res.error = 1'b1;
        end else begin
          // span reaches 2^32 and gen_state reaches M. The product still fits in 64 bits.
          span = 64'(longint'($signed(hi)) - longint'($signed(lo)) + 64'sd1);
          gen_state = lehmer_next(gen_state);
          scaled = (64'(gen_state) * span) / 64'(LRG_MOD);
          res.range_value = lo + scaled[31:0];
        end
      end
    endcase
    res.state = gen_state;
    return res;
  endfunction

  // Idle length for either side: mostly none, often a short gap, sometimes a long pause.
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_phase || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offers one word and waits for the handshake. The caller is always at a rising edge.
  // When there is no gap, in_tvalid stays high, so it gets a single assignment per step.
  task automatic send_word(input logic [1:0] op, input logic [31:0] seed,
                           input logic [30:0] thr, input logic [31:0] lo,
                           input logic [31:0] hi, input logic typed,
                           input lehmer_result_t known_res);
    int             gap;
    lehmer_result_t pred;
    gap = idle_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {1'b0, hi, lo, thr, seed};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    // The predictor always runs, so that its state stays in step on typed rows too.
    pred = lehmer_apply(op, seed, thr, lo, hi);
    pending_results.push_back(typed ? known_res : pred);
    words_accepted++;
    op_count[op]++;
    if (pred.error) range_errors++;
  endtask

  // Receiver: ready runs that alternate with random stalls, plus one long hold-off while
  // the sender keeps offering, so that the block fills up and stalls its input.
  initial begin
    out_tready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!hold_done && words_accepted >= HOLD_AFTER) begin
        hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      if (!quiet_phase) begin
        int stall;
        stall = idle_gap();
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  // Result monitor. It samples at the rising edge, before the block's registers move.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result word with no expectation pending: tdata=%h tuser=%b",
               out_tdata, out_tuser);
        failures++;
      end else begin
        if (out_tdata[30:0] !== pending_results[0].state) begin
          $error("state_out: expected %0d, actual %0d", pending_results[0].state,
                 out_tdata[30:0]);
          failures++;
        end
        if (out_tdata[31] !== pending_results[0].coin) begin
          $error("coin: expected %0b, actual %0b", pending_results[0].coin, out_tdata[31]);
          failures++;
        end
        if (out_tdata[63:32] !== pending_results[0].range_value) begin
          $error("range_value: expected %0d, actual %0d",
                 $signed(pending_results[0].range_value), $signed(out_tdata[63:32]));
          failures++;
        end
        if (out_tuser !== pending_results[0].error) begin
          $error("error: expected %0b, actual %0b", pending_results[0].error, out_tuser);
          failures++;
        end
        void'(pending_results.pop_front());
      end
    end
  end

  // Stimulus: reset, the directed table, then random words.
  initial begin
    logic [1:0]  op;
    logic [31:0] seed;
    logic [30:0] thr;
    logic [30:0] nxt;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] a;
    logic [31:0] b;
    int          pick;

    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tuser  = OP_SEED;
    in_tdata  = '0;
    gen_state = LRG_INIT;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (int k = 0; k < DIRECTED_COUNT; k++) begin
      send_word(DIRECTED_ROWS[k].op, DIRECTED_ROWS[k].seed, DIRECTED_ROWS[k].thr,
                DIRECTED_ROWS[k].lo, DIRECTED_ROWS[k].hi, DIRECTED_ROWS[k].typed,
                DIRECTED_ROWS[k].known_res);
    end

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      // Two stretches run back to back with no idling on either side.
      quiet_phase = (i >= 700 && i < 900) || (i >= 1500 && i < 1650);

      pick = $urandom_range(0, 99);
      if (pick < 15) op = OP_SEED;
      else if (pick < 40) op = OP_DRAW;
      else if (pick < 65) op = OP_BERN;
      else op = OP_RANGE;

      // Seeds: mostly random, sometimes zero, +-M, the most negative value, +-1.
      if ($urandom_range(0, 99) < 10) begin
        case ($urandom_range(0, 5))
          0: seed = 32'd0;
          1: seed = INT_MAX;
          2: seed = 32'h8000_0001;
          3: seed = INT_MIN;
          4: seed = 32'hFFFF_FFFF;
          default: seed = 32'd1;
        endcase
      end else begin
        seed = $urandom;
      end

      // Thresholds: some sit right at the coming state, to hit the strict compare.
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        nxt = lehmer_next(gen_state);
        thr = (nxt == LRG_MOD) ? LRG_MOD : nxt + 31'($urandom_range(0, 1));
      end else if (pick < 30) begin
        thr = pick[0] ? THR_MAX : 31'd0;
      end else begin
        thr = 31'($urandom);
      end

      // Bounds: inverted pairs, narrow spans (which may wrap and invert), the full
      // range, single-value ranges at the extremes, and wide ordered spans.
      a = $urandom;
      b = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        if (a == b) b = a ^ 32'd1;
        if ($signed(a) > $signed(b)) begin
          lo = a;
          hi = b;
        end else begin
          lo = b;
          hi = a;
        end
      end else if (pick < 45) begin
        lo = a;
        hi = a + 32'($urandom_range(0, 20));
      end else if (pick < 49) begin
        lo = INT_MIN;
        hi = INT_MAX;
      end else if (pick < 52) begin
        lo = pick[0] ? INT_MAX : INT_MIN;
        hi = lo;
      end else if ($signed(a) > $signed(b)) begin
        lo = b;
        hi = a;
      end else begin
        lo = a;
        hi = b;
      end

      send_word(op, seed, thr, lo, hi, 1'b0, '0);
    end
    quiet_phase = 1'b0;
    in_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d words: %0d reseeds, %0d draws, %0d Bernoulli tests, %0d ranges",
             words_accepted, op_count[OP_SEED], op_count[OP_DRAW], op_count[OP_BERN],
             op_count[OP_RANGE]);
    $display("%0d ranges had inverted bounds; the receiver held off once for %0d cycles.",
             range_errors, HOLD_CYCLES);
    if (failures == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: this is many times the slowest correct run.
  initial begin
    #2_000_000;
    $display("Timeout with %0d result words still pending", pending_results.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
